### rtl/modrm_pkg.sv
// Shared types, codes and decode helpers for the ModR/M operand unit.
package modrm_pkg;

    // Input transaction payload
    typedef struct packed {
        logic        mode;
        logic [7:0]  modrm_byte;
        logic [7:0]  disp_low;
        logic [7:0]  disp_high;
        logic        word_size;
        logic [15:0] write_value;
        logic [15:0] ds_value;
        logic [15:0] ss_value;
        logic        override_valid;
        logic [15:0] override_segment;
    } cmd_item_t;

    // Result transaction payload
    typedef struct packed {
        logic [1:0]  mod_field;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic        is_register;
        logic [15:0] offset;
        logic [15:0] segment;
        logic [1:0]  disp_bytes;
        logic [15:0] rm_value;
        logic [15:0] reg_value;
    } rsp_item_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_INDEX,
        ST_DONE
    } seq_state_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic sel_index;
        logic capture_first;
        logic finish;
    } seq_ctrl_t;

    // Mode field codes
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    // r/m code of the direct-address form under MOD_NO_DISP
    localparam logic [2:0] RM_DIRECT = 3'd6;

    // Register file indexes
    localparam logic [2:0] REG_BX = 3'd3;
    localparam logic [2:0] REG_BP = 3'd5;
    localparam logic [2:0] REG_SI = 3'd6;
    localparam logic [2:0] REG_DI = 3'd7;

    // Displacement byte counts
    localparam logic [1:0] DISP_NONE = 2'd0;
    localparam logic [1:0] DISP_ONE  = 2'd1;
    localparam logic [1:0] DISP_TWO  = 2'd2;

    // Map an operand code to the register file entry that holds it
    function automatic logic [2:0] phys_index(logic [2:0] idx, logic word);
        return word ? idx : {1'b0, idx[1:0]};
    endfunction

    // Select the operand bits out of a full register, zero-extended at byte width
    function automatic logic [15:0] pick_operand(logic [15:0] data, logic [2:0] idx,
                                                 logic word);
        logic [15:0] res;
        if (word)
            res = data;
        else if (idx[2])
            res = {8'h00, data[15:8]};
        else
            res = {8'h00, data[7:0]};
        return res;
    endfunction

    // Base register of a memory form
    function automatic logic [2:0] base_index(logic [2:0] rm);
        logic [2:0] res;
        case (rm) inside
            3'd0, 3'd1, 3'd7: res = REG_BX;
            3'd2, 3'd3, 3'd6: res = REG_BP;
            3'd4:             res = REG_SI;
            default:          res = REG_DI;
        endcase
        return res;
    endfunction

    // Index register of a two-register memory form
    function automatic logic [2:0] index_index(logic [2:0] rm);
        return rm[0] ? REG_DI : REG_SI;
    endfunction

    // BP-based forms default to the stack segment
    function automatic logic stack_default(logic [2:0] rm);
        logic res;
        case (rm) inside
            3'd2, 3'd3, 3'd6: res = 1'b1;
            default:          res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

### rtl/modrm_regfile.sv
// General register file: 8x16 memory, two registered read ports, one write port.
module modrm_regfile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  rd0_addr,
    input  logic [2:0]  rd1_addr,
    output logic [15:0] rd0_data,
    output logic [15:0] rd1_data,
    input  logic        wr_en,
    input  logic [2:0]  wr_addr,
    input  logic [15:0] wr_data
);

    logic [15:0] gpr_mem [8];
    logic [7:0]  valid_reg;
    logic [15:0] rd0_data_reg;
    logic [15:0] rd1_data_reg;
    logic        rd0_valid_reg;
    logic        rd1_valid_reg;

    // Write the memory array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gpr_mem[wr_addr] <= wr_data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rd0_data_reg <= gpr_mem[rd0_addr];
        rd1_data_reg <= gpr_mem[rd1_addr];
    end

    // Register the entry valid flags with the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd0_valid_reg <= 1'b0;
            rd1_valid_reg <= 1'b0;
        end
        else
        begin
            rd0_valid_reg <= valid_reg[rd0_addr];
            rd1_valid_reg <= valid_reg[rd1_addr];
        end
    end

    // Unwritten entries read as zero
    assign rd0_data = rd0_valid_reg ? rd0_data_reg : 16'h0000;
    assign rd1_data = rd1_valid_reg ? rd1_data_reg : 16'h0000;

endmodule

### rtl/modrm_seq.sv
// Sequencer: accepts one transaction, steps through the register reads, finishes.
module modrm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  modrm_pkg::cmd_item_t cmd,
    input  logic                 out_free,
    output modrm_pkg::cmd_item_t item,
    output modrm_pkg::seq_ctrl_t ctrl
);

    modrm_pkg::seq_state_t state_reg;
    modrm_pkg::seq_state_t state_next;
    modrm_pkg::cmd_item_t  item_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            modrm_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = modrm_pkg::ST_READ;
            end
            modrm_pkg::ST_READ:
            begin
                state_next = modrm_pkg::ST_INDEX;
            end
            modrm_pkg::ST_INDEX:
            begin
                state_next = modrm_pkg::ST_DONE;
            end
            modrm_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = modrm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = modrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs per state
    always_comb
    begin
        cmd_ready          = 1'b0;
        ctrl.sel_index     = 1'b0;
        ctrl.capture_first = 1'b0;
        ctrl.finish        = 1'b0;
        case (state_reg)
            modrm_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            modrm_pkg::ST_READ:
            begin
                ctrl.sel_index = 1'b0;
            end
            modrm_pkg::ST_INDEX:
            begin
                ctrl.sel_index     = 1'b1;
                ctrl.capture_first = 1'b1;
            end
            modrm_pkg::ST_DONE:
            begin
                ctrl.sel_index = 1'b1;
                ctrl.finish    = out_free;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modrm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            item_reg <= cmd;
        end
    end

    assign item = item_reg;

endmodule

### rtl/modrm_ea.sv
// Datapath: read addresses, effective address, segment, operands and write-back.
module modrm_ea (
    input  logic                 clk,
    input  modrm_pkg::cmd_item_t item,
    input  modrm_pkg::seq_ctrl_t ctrl,
    output logic [2:0]           rd0_addr,
    output logic [2:0]           rd1_addr,
    input  logic [15:0]          rd0_data,
    input  logic [15:0]          rd1_data,
    output logic                 wr_en,
    output logic [2:0]           wr_addr,
    output logic [15:0]          wr_data,
    output modrm_pkg::rsp_item_t result
);

    logic [1:0]  mod_f;
    logic [2:0]  reg_f;
    logic [2:0]  rm_f;
    logic        is_reg;
    logic        is_direct;
    logic [15:0] first_reg;
    logic [15:0] disp16;
    logic [15:0] disp_add;
    logic [15:0] index_val;
    logic [15:0] ea_sum;

    assign mod_f     = item.modrm_byte[7:6];
    assign reg_f     = item.modrm_byte[5:3];
    assign rm_f      = item.modrm_byte[2:0];
    assign is_reg    = (mod_f == modrm_pkg::MOD_REG);
    assign is_direct = (mod_f == modrm_pkg::MOD_NO_DISP) && (rm_f == modrm_pkg::RM_DIRECT);
    assign disp16    = {item.disp_high, item.disp_low};

    // Port 0 reads the reg operand; port 1 reads r/m or base, then the index
    assign rd0_addr = modrm_pkg::phys_index(reg_f, item.word_size);
    always_comb
    begin
        if (ctrl.sel_index)
            rd1_addr = modrm_pkg::index_index(rm_f);
        else if (is_reg)
            rd1_addr = modrm_pkg::phys_index(rm_f, item.word_size);
        else
            rd1_addr = modrm_pkg::base_index(rm_f);
    end

    // Hold the r/m or base register read
    always_ff @(posedge clk)
    begin
        if (ctrl.capture_first)
        begin
            first_reg <= rd1_data;
        end
    end

    // Displacement term
    always_comb
    begin
        case (mod_f)
            modrm_pkg::MOD_DISP8:  disp_add = {{8{item.disp_low[7]}}, item.disp_low};
            modrm_pkg::MOD_DISP16: disp_add = disp16;
            default:               disp_add = 16'h0000;
        endcase
    end

    // Base plus index plus displacement, wrapping to 16 bits
    assign index_val = rm_f[2] ? 16'h0000 : rd1_data;
    assign ea_sum    = first_reg + index_val + disp_add;

    // Assemble the result
    always_comb
    begin
        result.mod_field   = mod_f;
        result.reg_field   = reg_f;
        result.rm_field    = rm_f;
        result.is_register = is_reg;
        result.reg_value   = modrm_pkg::pick_operand(rd0_data, reg_f, item.word_size);
        result.rm_value    = 16'h0000;
        result.offset      = ea_sum;
        result.segment     = item.override_valid ? item.override_segment : item.ds_value;
        result.disp_bytes  = modrm_pkg::DISP_NONE;
        if (is_reg)
        begin
            result.rm_value = modrm_pkg::pick_operand(first_reg, rm_f, item.word_size);
            result.offset   = 16'h0000;
            result.segment  = item.ds_value;
        end
        else if (is_direct)
        begin
            result.offset     = disp16;
            result.disp_bytes = modrm_pkg::DISP_TWO;
        end
        else
        begin
            if (!item.override_valid && modrm_pkg::stack_default(rm_f))
                result.segment = item.ss_value;
            if (mod_f == modrm_pkg::MOD_DISP8)
                result.disp_bytes = modrm_pkg::DISP_ONE;
            else if (mod_f == modrm_pkg::MOD_DISP16)
                result.disp_bytes = modrm_pkg::DISP_TWO;
        end
    end

    // Merge the written value into the r/m register
    assign wr_en   = ctrl.finish && item.mode && is_reg;
    assign wr_addr = modrm_pkg::phys_index(rm_f, item.word_size);
    always_comb
    begin
        if (item.word_size)
            wr_data = item.write_value;
        else if (rm_f[2])
            wr_data = {item.write_value[7:0], first_reg[7:0]};
        else
            wr_data = {first_reg[15:8], item.write_value[7:0]};
    end

endmodule

### rtl/modrm_operand_unit_8086.sv
// Once cmd is accepted the sequencer steps through READ, INDEX and DONE; rsp_valid rises when
// DONE finishes with the result register free. A new transaction waits for the operand/base
// read, index read, finish and the idle state raising cmd_ready (reads share memory ports).
// A waiting result does not block acceptance; only the finish step waits for it.
// Reset: rst_n clears the sequencer, result valid and the register valid bits at once,
// so all eight general registers read zero; there is no clearing pass.
module modrm_operand_unit_8086 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  modrm_pkg::cmd_item_t cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output modrm_pkg::rsp_item_t rsp
);

    modrm_pkg::cmd_item_t item;
    modrm_pkg::seq_ctrl_t ctrl;
    modrm_pkg::rsp_item_t result;
    modrm_pkg::rsp_item_t rsp_reg;
    logic                 rsp_valid_reg;
    logic                 out_free;
    logic [2:0]           rd0_addr;
    logic [2:0]           rd1_addr;
    logic [15:0]          rd0_data;
    logic [15:0]          rd1_data;
    logic                 wr_en;
    logic [2:0]           wr_addr;
    logic [15:0]          wr_data;

    assign out_free = !rsp_valid_reg || rsp_ready;

    modrm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_free  (out_free),
        .item      (item),
        .ctrl      (ctrl)
    );

    modrm_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    modrm_ea u_ea (
        .clk      (clk),
        .item     (item),
        .ctrl     (ctrl),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .result   (result)
    );

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // One transaction in flight: no acceptance right after an acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd accepted while a transaction is in flight");

    // A register write always comes with a register-form result
    a_write_register_form: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> rsp_valid && rsp.is_register)
        else $error("register write without a register-form result");

    // Result fields stay consistent
    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.disp_bytes != 2'd3) && (!rsp.is_register || rsp.offset == 16'h0000))
        else $error("inconsistent result fields");

    // Finishing never overwrites a result that is not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |-> !rsp_valid || rsp_ready)
        else $error("result overwritten before it was taken");

endmodule
